[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this project.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TMI_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TMI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tmi_pkg.sv]
// Types and constants shared by the tape machine interpreter core.
// No dependencies; the front end, executor, top level and checker import this package.
`timescale 1ns / 1ps

package tmi_pkg;

    // Command characters of the tape language.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [15:0] SKIP_MAX = 16'hFFFF;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INC,
        OP_DEC,
        OP_LEFT,
        OP_RIGHT,
        OP_READ,
        OP_WRITE,
        OP_OPEN,
        OP_CLOSE
    } t_op;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_END = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    // Decoded instruction as it travels from the front end to the executor.
    typedef struct packed {
        t_op        op;
        logic       at_end;
        logic [7:0] in_byte;
    } t_cmd;

    typedef struct packed {
        logic [15:0] next_addr;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        in_used;
        t_status     status;
    } t_result;

endpackage

[rtl/tmi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the tape and the loop return stack.
`timescale 1ns / 1ps

module tmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tmi_fifo.sv]
// Small synchronous queue of register entries, generic in item type and depth.
// Depends on nothing; separates front end from executor and buffers results.
`timescale 1ns / 1ps

module tmi_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/tmi_front.sv]
// Front end: accepts instruction transfers and decodes them into commands.
// Depends on tmi_pkg; feeds the command queue in front of the executor.
`timescale 1ns / 1ps

module tmi_front
    import tmi_pkg::*;
(
    input  logic       i_push,
    input  logic [7:0] i_instr,
    input  logic [7:0] i_in_byte,
    input  logic       i_program_end,
    input  logic       i_queue_full,
    input  logic       i_clearing,
    output logic       o_full,
    output logic       o_queue_push,
    output t_cmd       o_cmd
);

    t_op w_op;

    always_comb begin
        unique case (i_instr)
            CH_PLUS:  w_op = OP_INC;
            CH_MINUS: w_op = OP_DEC;
            CH_LEFT:  w_op = OP_LEFT;
            CH_RIGHT: w_op = OP_RIGHT;
            CH_COMMA: w_op = OP_READ;
            CH_DOT:   w_op = OP_WRITE;
            CH_OPEN:  w_op = OP_OPEN;
            CH_CLOSE: w_op = OP_CLOSE;
            default:  w_op = OP_NONE;
        endcase
    end

    // No transfer is taken while the tape is still being cleared.
    assign o_full         = i_queue_full || i_clearing;
    assign o_queue_push   = i_push && !o_full;
    assign o_cmd.op       = w_op;
    assign o_cmd.at_end   = i_program_end;
    assign o_cmd.in_byte  = i_in_byte;

endmodule

[rtl/tmi_back.sv]
// Executor: runs decoded commands against the tape, head, program counter
// and loop stack. Depends on tmi_pkg and tmi_ram.
`timescale 1ns / 1ps

module tmi_back
    import tmi_pkg::*;
#(
    parameter int TAPE_CELLS  = 32768,
    parameter int STACK_DEPTH = 256,
    parameter int ADDR_BITS   = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res,
    output logic    o_clearing
);

    localparam int HW  = $clog2(TAPE_CELLS);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam logic [HW-1:0]  HEAD_MAX   = HW'(TAPE_CELLS - 1);
    localparam logic [SCW-1:0] STACK_FULL = SCW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [HW-1:0]        r_clr_addr, n_clr_addr;
    logic [HW-1:0]        r_head, n_head;
    logic [ADDR_BITS-1:0] r_pc, n_pc;
    logic [SCW-1:0]       r_stack_count, n_stack_count;
    logic [15:0]          r_skip, n_skip;
    logic                 r_stopped, n_stopped;
    t_status              r_stop_code, n_stop_code;
    t_cmd                 r_cmd, n_cmd;

    logic                 w_tape_we;
    logic [HW-1:0]        w_tape_waddr;
    logic [7:0]           w_tape_wdata;
    logic [7:0]           w_cell;
    logic                 w_stk_we;
    logic [ADDR_BITS-1:0] w_stk_top;
    logic [SCW-1:0]       w_top_cnt;
    logic [ADDR_BITS-1:0] w_pc_inc;
    logic [ADDR_BITS-1:0] w_next;
    logic [31:0]          w_next_ext;

    assign w_top_cnt  = r_stack_count - 1'b1;
    assign w_pc_inc   = r_pc + 1'b1;
    assign w_next_ext = 32'(w_next);
    assign o_clearing = (r_state == S_CLEAR);

    tmi_ram #(
        .WIDTH (8),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_tape_we),
        .i_waddr (w_tape_waddr),
        .i_wdata (w_tape_wdata),
        .i_raddr (r_head),
        .o_rdata (w_cell)
    );

    // The return address pushed by an open bracket is the one after it.
    tmi_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_stack_count[SAW-1:0]),
        .i_wdata (w_pc_inc),
        .i_raddr (w_top_cnt[SAW-1:0]),
        .o_rdata (w_stk_top)
    );

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_head        = r_head;
        n_pc          = r_pc;
        n_stack_count = r_stack_count;
        n_skip        = r_skip;
        n_stopped     = r_stopped;
        n_stop_code   = r_stop_code;
        n_cmd         = r_cmd;
        w_tape_we     = 1'b0;
        w_tape_waddr  = r_head;
        w_tape_wdata  = w_cell;
        w_stk_we      = 1'b0;
        w_next        = r_pc;
        o_cmd_pop     = 1'b0;
        o_res_push    = 1'b0;
        o_res         = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_tape_we    = 1'b1;
                w_tape_waddr = r_clr_addr;
                w_tape_wdata = '0;
                if (r_clr_addr == HEAD_MAX) begin
                    n_state = S_FETCH;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_FETCH: begin
                // The tape and stack reads at the current head and top of
                // stack are issued in this cycle and return in S_EXEC.
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    n_state      = S_FETCH;
                    o_res.status = ST_RUN;
                    if (r_stopped) begin
                        o_res.status = r_stop_code;
                    end else if (r_cmd.at_end) begin
                        n_stopped    = 1'b1;
                        n_stop_code  = ST_END;
                        o_res.status = ST_END;
                    end else if (r_skip != '0) begin
                        w_next = w_pc_inc;
                        if (r_cmd.op == OP_OPEN && r_skip != SKIP_MAX) begin
                            n_skip = r_skip + 1'b1;
                        end else if (r_cmd.op == OP_CLOSE) begin
                            n_skip = r_skip - 1'b1;
                        end
                    end else begin
                        w_next = w_pc_inc;
                        unique case (r_cmd.op)
                            OP_INC: begin
                                w_tape_we    = 1'b1;
                                w_tape_wdata = w_cell + 1'b1;
                            end
                            OP_DEC: begin
                                w_tape_we    = 1'b1;
                                w_tape_wdata = w_cell - 1'b1;
                            end
                            OP_LEFT: begin
                                n_head = (r_head == '0) ? HEAD_MAX : r_head - 1'b1;
                            end
                            OP_RIGHT: begin
                                n_head = (r_head == HEAD_MAX) ? '0 : r_head + 1'b1;
                            end
                            OP_READ: begin
                                w_tape_we     = 1'b1;
                                w_tape_wdata  = r_cmd.in_byte;
                                o_res.in_used = 1'b1;
                            end
                            OP_WRITE: begin
                                o_res.out_byte  = w_cell;
                                o_res.out_valid = 1'b1;
                            end
                            OP_OPEN: begin
                                if (w_cell == '0) begin
                                    n_skip = 16'd1;
                                end else if (r_stack_count == STACK_FULL) begin
                                    // Overflow halts with the address left on the bracket.
                                    n_stopped    = 1'b1;
                                    n_stop_code  = ST_OVF;
                                    o_res.status = ST_OVF;
                                    w_next       = r_pc;
                                end else begin
                                    w_stk_we      = 1'b1;
                                    n_stack_count = r_stack_count + 1'b1;
                                end
                            end
                            OP_CLOSE: begin
                                // A close bracket with an empty stack is ignored.
                                if (r_stack_count != '0) begin
                                    if (w_cell != '0) begin
                                        w_next = w_stk_top;
                                    end else begin
                                        n_stack_count = r_stack_count - 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    n_pc            = w_next;
                    o_res.next_addr = w_next_ext[15:0];
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_head        <= '0;
            r_pc          <= '0;
            r_stack_count <= '0;
            r_skip        <= '0;
            r_stopped     <= 1'b0;
            r_stop_code   <= ST_RUN;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_head        <= n_head;
            r_pc          <= n_pc;
            r_stack_count <= n_stack_count;
            r_skip        <= n_skip;
            r_stopped     <= n_stopped;
            r_stop_code   <= n_stop_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

[rtl/tape_machine_interpreter_core_top.sv]
// Tape machine interpreter core, top level: front end, command queue,
// executor and result queue. Depends on tmi_pkg, tmi_front, tmi_fifo, tmi_back.
`timescale 1ns / 1ps

// Each transfer on the input side carries one program byte, fetched from the
// next_addr of the previous result (address 0 first), with an input byte and
// a past-the-end flag; each yields exactly one result transfer. The executor
// runs one instruction at a time through S_FETCH, then S_EXEC, for the
// read-modify-write of the current cell in the tape RAM: read in S_FETCH and
// updated in S_EXEC. A two-entry command queue and a two-entry result queue
// let both sides stall independently. After reset the tape is cleared one
// cell per cycle, all TAPE_CELLS (32768 by default); full stays high meanwhile.
module tape_machine_interpreter_core_top
    import tmi_pkg::*;
#(
    parameter int TAPE_CELLS  = 32768,
    parameter int STACK_DEPTH = 256,
    parameter int ADDR_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_instr,
    input  logic [7:0]  i_in_byte,
    input  logic        i_program_end,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_next_addr,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_in_used,
    output logic [1:0]  o_status
);

    t_cmd    w_front_cmd;
    t_cmd    w_queue_cmd;
    logic    w_cmd_push;
    logic    w_cmd_pop;
    logic    w_cmd_full;
    logic    w_cmd_empty;
    logic    w_clearing;
    t_result w_back_res;
    t_result w_out_res;
    logic    w_res_push;
    logic    w_res_full;

    tmi_front u_front (
        .i_push        (push),
        .i_instr       (i_instr),
        .i_in_byte     (i_in_byte),
        .i_program_end (i_program_end),
        .i_queue_full  (w_cmd_full),
        .i_clearing    (w_clearing),
        .o_full        (full),
        .o_queue_push  (w_cmd_push),
        .o_cmd         (w_front_cmd)
    );

    tmi_fifo #(
        .t_item (t_cmd),
        .DEPTH  (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_cmd_pop),
        .o_data  (w_queue_cmd),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty)
    );

    tmi_back #(
        .TAPE_CELLS  (TAPE_CELLS),
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_queue_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res),
        .o_clearing  (w_clearing)
    );

    tmi_fifo #(
        .t_item (t_result),
        .DEPTH  (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_back_res),
        .i_pop   (pop),
        .o_data  (w_out_res),
        .o_full  (w_res_full),
        .o_empty (empty)
    );

    assign o_next_addr = w_out_res.next_addr;
    assign o_out_byte  = w_out_res.out_byte;
    assign o_out_valid = w_out_res.out_valid;
    assign o_in_used   = w_out_res.in_used;
    assign o_status    = w_out_res.status;

endmodule

[rtl/tmi_checker.sv]
// Port-level checker for the tape machine interpreter core, bound to the top.
// Depends on tmi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmi_checker
    import tmi_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_next_addr,
    input logic [7:0]  o_out_byte,
    input logic        o_out_valid,
    input logic        o_in_used,
    input logic [1:0]  o_status
);

    // Right after reset the tape clear is running and no result exists yet.
    `TMI_ASSERT_SAME(a_reset_clear, $rose(i_rst_n), full && empty, "no clearing pass after reset")

    // A halted step neither emits nor consumes a byte.
    `TMI_ASSERT_SAME(a_halt_quiet, !empty && o_status != ST_RUN, !o_out_valid && !o_in_used, "halted result has side effects")

    // An instruction never both reads and writes a byte, and idle bytes are zero.
    `TMI_ASSERT_SAME(a_byte_flags, !empty, !(o_out_valid && o_in_used) && (o_out_valid || o_out_byte == 8'd0), "inconsistent byte flags")

    `TMI_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(o_next_addr), "waiting result changed")

endmodule

bind tape_machine_interpreter_core_top tmi_checker u_checker (.*);
